// ===== rtl/lifn_pkg.sv =====
// ----------------------------------------------------------------------------
// lifn_pkg: shared types, constants and arithmetic helpers
// Item, state-entry and configuration types of the neuron core, with the
// saturating add, factor clamp and other Q16.16 helpers used by the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
package lifn_pkg;

    localparam int NEURONS    = 1024;
    localparam int NW         = $clog2(NEURONS);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0]  REFR_STEPS = 8'd2;
    localparam logic [16:0] ONE_Q16    = 17'd65536;

    localparam logic [1:0] KIND_LEAK   = 2'd0;
    localparam logic [1:0] KIND_ARRIVE = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] PATH_FF   = 2'd0;
    localparam logic [1:0] PATH_PRED = 2'd1;

    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_PLUS = 2'd1;

    localparam logic [2:0] CFG_MODE       = 3'd0;
    localparam logic [2:0] CFG_CUR_LEAK   = 3'd1;
    localparam logic [2:0] CFG_MEM_LEAK   = 3'd2;
    localparam logic [2:0] CFG_MEM_GAIN   = 3'd3;
    localparam logic [2:0] CFG_SENS_LEAK  = 3'd4;
    localparam logic [2:0] CFG_ADAPT_LEAK = 3'd5;
    localparam logic [2:0] CFG_THRESHOLD  = 3'd6;
    localparam logic [2:0] CFG_JUMP       = 3'd7;

    typedef struct packed {
        logic [1:0]        kind;
        logic [NW-1:0]     neuron;
        logic [1:0]        pathway;
        logic signed [31:0] w;
        logic [16:0]       cdecay;
        logic [16:0]       mdecay;
        logic signed [31:0] rest;
        logic signed [31:0] inj;
        logic              silenced;
    } item_t;

    typedef struct packed {
        logic signed [31:0] ff;
        logic signed [31:0] pred;
        logic signed [31:0] behav;
        logic signed [31:0] sens;
        logic signed [31:0] adapt;
        logic signed [31:0] volt;
        logic [7:0]         refr;
        logic signed [31:0] incr;
    } entry_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [16:0]        cur_leak;
        logic [16:0]        mem_leak;
        logic [16:0]        mem_gain;
        logic [16:0]        sens_leak;
        logic [16:0]        adapt_leak;
        logic signed [31:0] thr;
        logic [30:0]        jump;
    } cfg_t;

    typedef struct packed {
        logic clearing;
        logic fin;
    } back_stat_t;

    function automatic logic [16:0] clamp_f(input logic [16:0] f);
        return (f > ONE_Q16) ? ONE_Q16 : f;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return s[31:0];
    endfunction

    // Full-width product of a value and a factor; q16 then takes bits 47:16, which rounds down.
    function automatic logic signed [49:0] mul_f(input logic signed [31:0] x,
                                                 input logic [16:0] f);
        return x * $signed({1'b0, f});
    endfunction

    function automatic logic signed [31:0] q16(input logic signed [49:0] p);
        return p[47:16];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lifn_front.sv =====
// ----------------------------------------------------------------------------
// lifn_front: input acceptance and classification
// Accepts input words, drops those that cause no work, clamps the factors
// and forms the signed weight before queuing the item.
// ----------------------------------------------------------------------------
`default_nettype none
module lifn_front import lifn_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [151:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         q_full,
    input  wire logic         clearing,
    output logic              q_push,
    output item_t             q_item
);
    logic signed [31:0] weight;
    logic [1:0]         sgn;
    logic               in_range;

    assign s_tready = !q_full && !clearing;
    assign weight   = s_tdata[43:12];
    assign sgn      = s_tdata[45:44];
    assign in_range = 32'(s_tdata[NW-1:0]) < NEURONS;

    always_comb begin
        q_item.kind     = s_tuser;
        q_item.neuron   = s_tdata[NW-1:0];
        q_item.pathway  = s_tdata[11:10];
        q_item.cdecay   = clamp_f(s_tdata[62:46]);
        q_item.mdecay   = clamp_f(s_tdata[79:63]);
        q_item.rest     = s_tdata[111:80];
        q_item.inj      = s_tdata[143:112];
        q_item.silenced = s_tdata[144];
        // Negating the most negative weight saturates.
        if (sgn == SIGN_PLUS) begin
            q_item.w = weight;
        end else if (sgn == SIGN_ZERO) begin
            q_item.w = '0;
        end else if (weight == 32'sh8000_0000) begin
            q_item.w = 32'sh7fff_ffff;
        end else begin
            q_item.w = -weight;
        end
    end

    assign q_push = s_tvalid && s_tready && in_range && (s_tuser != KIND_NONE);

    // The front holds no state of its own; clock and reset are kept for
    // the common port set of the block's parts.
    logic unused_ok;
    assign unused_ok = aclk & aresetn & (|s_tdata[151:145]);
endmodule
`default_nettype wire

// ===== rtl/lifn_fifo.sv =====
// ----------------------------------------------------------------------------
// lifn_fifo: short item queue
// Two-entry queue between the front and back parts of the core.
// ----------------------------------------------------------------------------
`default_nettype none
module lifn_fifo import lifn_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire item_t       din,
    input  wire logic        pop,
    output item_t            dout,
    output logic             full,
    output logic             empty,
    output logic [FIFO_PW:0] count
);
    item_t              mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wr_reg, rd_reg;
    logic [FIFO_PW:0]   cnt_reg;
    logic               do_push, do_pop;

    assign full    = cnt_reg == (FIFO_PW+1)'(FIFO_DEPTH);
    assign empty   = cnt_reg == '0;
    assign count   = cnt_reg;
    assign dout    = mem[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (FIFO_PW+1)'(do_push) - (FIFO_PW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lifn_back.sv =====
// ----------------------------------------------------------------------------
// lifn_back: neuron state sequencer
// Holds the per-neuron state memory, clears it after reset and carries out
// leak, arrival and update items by read, compute and write back.
// ----------------------------------------------------------------------------
`default_nettype none
module lifn_back import lifn_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire cfg_t         cfg,
    input  wire logic         q_empty,
    input  wire item_t        q_item,
    output logic              q_pop,
    output back_stat_t        stat,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata
);
    localparam logic [3:0] B_CLEAR = 4'd0;
    localparam logic [3:0] B_IDLE  = 4'd1;
    localparam logic [3:0] B_READ  = 4'd2;
    localparam logic [3:0] B_MUL   = 4'd3;
    localparam logic [3:0] B_LWB   = 4'd4;
    localparam logic [3:0] B_U2    = 4'd5;
    localparam logic [3:0] B_U3    = 4'd6;
    localparam logic [3:0] B_U4    = 4'd7;
    localparam logic [3:0] B_U5    = 4'd8;
    localparam logic [3:0] B_U6    = 4'd9;
    localparam logic [3:0] B_U7    = 4'd10;
    localparam logic [3:0] B_U8    = 4'd11;

    entry_t mem [NEURONS];
    entry_t rd_reg;
    entry_t wdata;
    logic   we;
    logic [NW-1:0] waddr;

    logic [3:0]         state_reg, state_next;
    logic [NW:0]        clr_reg;
    item_t              item_reg;
    logic signed [49:0] p1_reg, p2_reg, p3_reg, mg_reg;
    logic signed [31:0] sens_reg, adapt_reg, vdec_reg, acc_reg, obs_reg, v_reg;
    logic               out_full, fin, spike, classes, eligible;
    logic [16:0]        fa, fb, fc, gain;
    logic signed [31:0] xa, xb, xc, arr_sum, adapt_new;
    logic [7:0]         refr_new;
    logic [143:0]       m_tdata_reg;
    logic               m_tvalid_reg;

    assign classes  = cfg.mode[0];
    assign out_full = m_tvalid_reg && !m_tready;
    assign fin      = (state_reg == B_U8) && !out_full;
    assign eligible = rd_reg.refr == 8'd0;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign stat.clearing = state_reg == B_CLEAR;
    assign stat.fin      = fin;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        if (item_reg.kind == KIND_LEAK) begin
            xa = rd_reg.ff;
            xb = rd_reg.pred;
            xc = rd_reg.behav;
            fa = classes ? item_reg.cdecay : cfg.cur_leak;
            fb = fa;
            fc = fa;
        end else begin
            xa = rd_reg.sens;
            xb = rd_reg.adapt;
            xc = rd_reg.volt;
            fa = cfg.sens_leak;
            fb = cfg.adapt_leak;
            fc = classes ? item_reg.mdecay : cfg.mem_leak;
        end
        gain = classes ? (ONE_Q16 - item_reg.mdecay) : cfg.mem_gain;
        if (item_reg.pathway == PATH_FF) begin
            arr_sum = add_sat(rd_reg.ff, item_reg.w);
        end else if (item_reg.pathway == PATH_PRED) begin
            arr_sum = add_sat(rd_reg.pred, item_reg.w);
        end else begin
            arr_sum = add_sat(rd_reg.behav, item_reg.w);
        end
        // Threshold plus adaptation is formed without saturation.
        spike = eligible && !item_reg.silenced &&
                ($signed({{2{v_reg[31]}}, v_reg}) >=
                 ($signed({{2{cfg.thr[31]}}, cfg.thr}) +
                  $signed({{2{adapt_reg[31]}}, adapt_reg})));
        adapt_new = spike ? add_sat(adapt_reg, $signed({1'b0, cfg.jump})) : adapt_reg;
        if (!eligible) begin
            refr_new = rd_reg.refr - 8'd1;
        end else begin
            refr_new = spike ? REFR_STEPS : 8'd0;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = item_reg.neuron;
        wdata = rd_reg;
        case (state_reg)
            B_CLEAR: begin
                we    = 1'b1;
                waddr = clr_reg[NW-1:0];
                wdata = '0;
            end
            B_MUL: begin
                if (item_reg.kind == KIND_ARRIVE) begin
                    we = 1'b1;
                    if (item_reg.pathway == PATH_FF) begin
                        wdata.ff   = arr_sum;
                        wdata.incr = add_sat(rd_reg.incr, item_reg.w);
                    end else if (item_reg.pathway == PATH_PRED) begin
                        wdata.pred = arr_sum;
                    end else begin
                        wdata.behav = arr_sum;
                    end
                end
            end
            B_LWB: begin
                we          = 1'b1;
                wdata.ff    = q16(p1_reg);
                wdata.pred  = q16(p2_reg);
                wdata.behav = q16(p3_reg);
                wdata.incr  = '0;
            end
            B_U8: begin
                we          = fin;
                wdata.sens  = sens_reg;
                wdata.adapt = adapt_new;
                wdata.volt  = spike ? 32'sd0 : v_reg;
                wdata.refr  = refr_new;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (state_reg == B_READ) begin
            rd_reg <= mem[item_reg.neuron];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: begin
                if (clr_reg == (NW+1)'(NEURONS - 1)) state_next = B_IDLE;
            end
            B_IDLE: begin
                if (!q_empty) state_next = B_READ;
            end
            B_READ: state_next = B_MUL;
            B_MUL: begin
                if (item_reg.kind == KIND_ARRIVE) begin
                    state_next = B_IDLE;
                end else if (item_reg.kind == KIND_LEAK) begin
                    state_next = B_LWB;
                end else begin
                    state_next = B_U2;
                end
            end
            B_LWB: state_next = B_IDLE;
            B_U2:  state_next = B_U3;
            B_U3:  state_next = B_U4;
            B_U4:  state_next = B_U5;
            B_U5:  state_next = B_U6;
            B_U6:  state_next = B_U7;
            B_U7:  state_next = B_U8;
            B_U8: begin
                if (fin) state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (fin) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        case (state_reg)
            B_MUL: begin
                p1_reg <= mul_f(xa, fa);
                p2_reg <= mul_f(xb, fb);
                p3_reg <= mul_f(xc, fc);
            end
            B_U2: begin
                sens_reg  <= cfg.mode[1] ? add_sat(q16(p1_reg), item_reg.inj) : item_reg.inj;
                adapt_reg <= q16(p2_reg);
                vdec_reg  <= q16(p3_reg);
            end
            B_U3: begin
                obs_reg <= add_sat(rd_reg.ff, sens_reg);
                acc_reg <= add_sat(add_sat(rd_reg.ff, sens_reg), rd_reg.pred);
            end
            B_U4: acc_reg <= add_sat(acc_reg, rd_reg.behav);
            B_U5: acc_reg <= add_sat(acc_reg, item_reg.rest);
            B_U6: mg_reg  <= mul_f(acc_reg, gain);
            B_U7: begin
                v_reg <= (!eligible || item_reg.silenced) ? 32'sd0
                                                          : add_sat(vdec_reg, q16(mg_reg));
            end
            default: begin
            end
        endcase
        if (fin) begin
            m_tdata_reg <= {5'd0, (spike ? 32'sd0 : v_reg), spike, rd_reg.incr,
                            rd_reg.pred, obs_reg, item_reg.neuron};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lif_neuron_core_step_core.sv =====
// Sequence: an item passes the queue, then the states READ and MUL; arrival
// items write back in MUL, leak items in LWB, and update items run U2 to U8
// and register their result word when U8 finishes. The single read-modify-write
// sequencer on the state memory takes the next item only after the last is done.
// Reset: configuration takes its defaults at once; a clearing pass over all 1024
// entries then zeroes the state memory, during which no input word is taken.
// ----------------------------------------------------------------------------
// lif_neuron_core_step_core: leaky integrate-and-fire neuron core
// Front part classifies input words, a short queue decouples it from the
// back part that updates per-neuron state and emits result words.
// ----------------------------------------------------------------------------
`default_nettype none
module lif_neuron_core_step_core import lifn_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // neuron, pathway, weight, sign, cdecay, mdecay, rest,
    // injection, silenced (lowest bit first)
    input  wire logic [151:0] s_tdata,
    // kind
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // neuron_out, observed, predicted, increment, spike, voltage_out
    output logic [143:0]      m_tdata
);
    cfg_t             cfg_reg;
    item_t            f_item, q_item;
    logic             q_push, q_pop, q_full, q_empty;
    logic [FIFO_PW:0] q_count;
    back_stat_t       stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode       <= 2'd0;
            cfg_reg.cur_leak   <= ONE_Q16;
            cfg_reg.mem_leak   <= ONE_Q16;
            cfg_reg.mem_gain   <= 17'd0;
            cfg_reg.sens_leak  <= 17'd0;
            cfg_reg.adapt_leak <= ONE_Q16;
            cfg_reg.thr        <= 32'sd65536;
            cfg_reg.jump       <= 31'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE:       cfg_reg.mode       <= cfg_wdata[1:0];
                CFG_CUR_LEAK:   cfg_reg.cur_leak   <= clamp_f(cfg_wdata[16:0]);
                CFG_MEM_LEAK:   cfg_reg.mem_leak   <= clamp_f(cfg_wdata[16:0]);
                CFG_MEM_GAIN:   cfg_reg.mem_gain   <= clamp_f(cfg_wdata[16:0]);
                CFG_SENS_LEAK:  cfg_reg.sens_leak  <= clamp_f(cfg_wdata[16:0]);
                CFG_ADAPT_LEAK: cfg_reg.adapt_leak <= clamp_f(cfg_wdata[16:0]);
                CFG_THRESHOLD:  cfg_reg.thr        <= cfg_wdata;
                CFG_JUMP:       cfg_reg.jump       <= cfg_wdata[30:0];
                default: begin
                end
            endcase
        end
    end

    lifn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .clearing (stat.clearing),
        .q_push   (q_push),
        .q_item   (f_item)
    );

    lifn_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (f_item),
        .pop     (q_pop),
        .dout    (q_item),
        .full    (q_full),
        .empty   (q_empty),
        .count   (q_count)
    );

    lifn_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A result word only appears after the sequencer finished an update.
    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(stat.fin))
        else $error("result word without a finished update");

    // No result can be produced while the state memory is being cleared.
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.clearing |-> !m_tvalid && q_empty)
        else $error("activity during the clearing pass");

    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= (FIFO_PW+1)'(FIFO_DEPTH))
        else $error("queue overfilled");

endmodule
`default_nettype wire

// ===== dv/tb_lif_neuron_core_step_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lif_neuron_core_step_core: self-checking bench of the neuron core
// Streams leak, arrival and update words with random gaps and back-pressure,
// predicts each update result from a model of the per-neuron state kept
// here, and compares every result word field by field.
// ----------------------------------------------------------------------------
module tb_lif_neuron_core_step_core;
    import lifn_pkg::*;

    typedef struct {
        logic [1:0]         kind;
        logic [9:0]         neuron;
        logic [1:0]         pathway;
        logic signed [31:0] weight;
        logic [1:0]         sgn;
        logic [16:0]        cdec;
        logic [16:0]        mdec;
        logic signed [31:0] rest;
        logic signed [31:0] inj;
        logic               sil;
    } word_t;

    typedef struct {
        logic [9:0]         neuron;
        logic signed [31:0] observed;
        logic signed [31:0] predicted;
        logic signed [31:0] increment;
        logic               spike;
        logic signed [31:0] voltage;
    } result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;

    lif_neuron_core_step_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Neuron state and configuration as the core should hold them.
    logic signed [31:0] ff_q [1024];
    logic signed [31:0] pred_q [1024];
    logic signed [31:0] behav_q [1024];
    logic signed [31:0] sens_q [1024];
    logic signed [31:0] adapt_q [1024];
    logic signed [31:0] volt_q [1024];
    logic [7:0]         refr_q [1024];
    logic signed [31:0] incr_q [1024];

    logic [1:0]         c_mode = 2'd0;
    logic [16:0]        c_cur_leak = ONE_Q16;
    logic [16:0]        c_mem_leak = ONE_Q16;
    logic [16:0]        c_mem_gain = 17'd0;
    logic [16:0]        c_sens_leak = 17'd0;
    logic [16:0]        c_adapt_leak = ONE_Q16;
    logic signed [31:0] c_thr = 32'sd65536;
    logic [30:0]        c_jump = 31'd0;

    word_t   pending_words[$];
    result_t due_results[$];
    int      fails = 0;
    int      cycles = 0;
    bit      quiet = 1'b0;

    initial begin
        for (int i = 0; i < 1024; i++) begin
            ff_q[i] = 0; pred_q[i] = 0; behav_q[i] = 0; sens_q[i] = 0;
            adapt_q[i] = 0; volt_q[i] = 0; refr_q[i] = 0; incr_q[i] = 0;
        end
    end

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [16:0] fclamp(input logic [16:0] f);
        return (f > 17'd65536) ? 17'd65536 : f;
    endfunction

    // Product with a Q1.16 factor, rounded toward minus infinity.
    function automatic logic signed [31:0] scale(input logic signed [31:0] x,
                                                 input logic [16:0] f);
        longint p;
        longint fl;
        fl = f;
        p = longint'(x) * fl;
        p = p >>> 16;
        return p[31:0];
    endfunction

    task automatic apply_word(input word_t w);
        int n;
        longint s;
        logic signed [31:0] wv, sens, obs, cur, adapt, v;
        logic [16:0] f, decay, gain;
        bit elig, spk, cls;
        result_t r;
        n = w.neuron;
        cls = c_mode[0];
        case (w.kind)
            KIND_LEAK: begin
                f = cls ? fclamp(w.cdec) : c_cur_leak;
                ff_q[n] = scale(ff_q[n], f);
                pred_q[n] = scale(pred_q[n], f);
                behav_q[n] = scale(behav_q[n], f);
                incr_q[n] = 0;
            end
            KIND_ARRIVE: begin
                s = (w.sgn == SIGN_PLUS) ? 1 : ((w.sgn == SIGN_ZERO) ? 0 : -1);
                wv = sat32(s * longint'(w.weight));
                if (w.pathway == PATH_FF) begin
                    ff_q[n] = sat32(longint'(ff_q[n]) + wv);
                    incr_q[n] = sat32(longint'(incr_q[n]) + wv);
                end else if (w.pathway == PATH_PRED) begin
                    pred_q[n] = sat32(longint'(pred_q[n]) + wv);
                end else begin
                    behav_q[n] = sat32(longint'(behav_q[n]) + wv);
                end
            end
            KIND_UPDATE: begin
                if (c_mode[1])
                    sens = sat32(longint'(scale(sens_q[n], c_sens_leak)) + w.inj);
                else
                    sens = w.inj;
                sens_q[n] = sens;
                obs = sat32(longint'(ff_q[n]) + sens);
                cur = sat32(longint'(obs) + pred_q[n]);
                cur = sat32(longint'(cur) + behav_q[n]);
                cur = sat32(longint'(cur) + w.rest);
                adapt = scale(adapt_q[n], c_adapt_leak);
                elig = (refr_q[n] == 8'd0);
                if (!elig) refr_q[n] = refr_q[n] - 8'd1;
                decay = cls ? fclamp(w.mdec) : c_mem_leak;
                gain = cls ? (ONE_Q16 - decay) : c_mem_gain;
                v = sat32(longint'(scale(volt_q[n], decay)) + scale(cur, gain));
                if (!elig || w.sil) v = 0;
                spk = elig && !w.sil && (longint'(v) >= longint'(c_thr) + longint'(adapt));
                if (spk) begin
                    v = 0;
                    refr_q[n] = REFR_STEPS;
                    adapt = sat32(longint'(adapt) + longint'({1'b0, c_jump}));
                end
                volt_q[n] = v;
                adapt_q[n] = adapt;
                r.neuron = w.neuron;
                r.observed = obs;
                r.predicted = pred_q[n];
                r.increment = incr_q[n];
                r.spike = spk;
                r.voltage = v;
                due_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: presents the next queued word after a random gap.
    word_t cur_word;
    bit    took = 1'b0;
    int    s_gap = 0;

    always @(posedge aclk) begin
        took = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            apply_word(cur_word);
            took = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (!s_tvalid || took) begin
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                cur_word = pending_words.pop_front();
                s_tdata <= {7'd0, cur_word.sil, cur_word.inj, cur_word.rest, cur_word.mdec,
                            cur_word.cdec, cur_word.sgn, cur_word.weight, cur_word.pathway,
                            cur_word.neuron};
                s_tuser <= cur_word.kind;
                s_tvalid <= 1'b1;
                s_gap <= gap_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: random back-pressure and field-wise comparison.
    int m_gap = 0;

    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            m_gap <= gap_len();
        end
    end

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch in %s at cycle %0d: got %h, expected %h", field, cycles, got, want);
        fails++;
    endtask

    always @(posedge aclk) begin
        result_t e;
        cycles++;
        if (cycles > 1000000) begin
            $display("lif_neuron_core_step_core regression: fail");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                report("unexpected word", m_tdata[31:0], 32'd0);
            end else begin
                e = due_results.pop_front();
                if (m_tdata[9:0] != e.neuron)
                    report("neuron_out", 32'(m_tdata[9:0]), 32'(e.neuron));
                if (m_tdata[41:10] != e.observed) report("observed", m_tdata[41:10], e.observed);
                if (m_tdata[73:42] != e.predicted)
                    report("predicted", m_tdata[73:42], e.predicted);
                if (m_tdata[105:74] != e.increment)
                    report("increment", m_tdata[105:74], e.increment);
                if (m_tdata[106] != e.spike)
                    report("spike", 32'(m_tdata[106]), 32'(e.spike));
                if (m_tdata[138:107] != e.voltage)
                    report("voltage_out", m_tdata[138:107], e.voltage);
            end
        end
    end

    function automatic word_t mk(input logic [1:0] k, input logic [9:0] n, input logic [1:0] p,
                                 input logic [31:0] w, input logic [1:0] sg,
                                 input logic [16:0] cd, input logic [16:0] md,
                                 input logic [31:0] rs, input logic [31:0] ij, input logic sl);
        word_t x;
        x.kind = k; x.neuron = n; x.pathway = p; x.weight = w; x.sgn = sg;
        x.cdec = cd; x.mdec = md; x.rest = rs; x.inj = ij; x.sil = sl;
        return x;
    endfunction

    function automatic logic [31:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        if (r < 8) return $urandom;
        return r[0] ? 32'h7fff_ffff : 32'h8000_0000;
    endfunction

    function automatic logic [16:0] rand_factor();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 17'($urandom_range(0, 65536));
        if (r < 9) return 17'($urandom);
        return ONE_Q16;
    endfunction

    function automatic word_t rand_word();
        word_t x;
        int r;
        r = $urandom_range(0, 99);
        x.kind = (r < 15) ? KIND_LEAK : (r < 60) ? KIND_ARRIVE : (r < 95) ? KIND_UPDATE
                                                                           : KIND_NONE;
        x.neuron = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 7)) : 10'($urandom);
        x.pathway = 2'($urandom);
        x.weight = rand_value();
        x.sgn = 2'($urandom);
        x.cdec = rand_factor();
        x.mdec = rand_factor();
        x.rest = rand_value();
        x.inj = rand_value();
        x.sil = ($urandom_range(0, 9) == 0);
        return x;
    endfunction

    task automatic wait_idle();
        while (pending_words.size() > 0 || s_tvalid || due_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MODE:       c_mode = val[1:0];
            CFG_CUR_LEAK:   c_cur_leak = fclamp(val[16:0]);
            CFG_MEM_LEAK:   c_mem_leak = fclamp(val[16:0]);
            CFG_MEM_GAIN:   c_mem_gain = fclamp(val[16:0]);
            CFG_SENS_LEAK:  c_sens_leak = fclamp(val[16:0]);
            CFG_ADAPT_LEAK: c_adapt_leak = fclamp(val[16:0]);
            CFG_THRESHOLD:  c_thr = val;
            default:        c_jump = val[30:0];
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input int phase);
        case (phase)
            0: begin
                // Every factor written above one, threshold and jump at their largest.
                write_reg(CFG_MODE, 32'd3);
                write_reg(CFG_CUR_LEAK, 32'h1ffff);
                write_reg(CFG_MEM_LEAK, 32'h1ffff);
                write_reg(CFG_MEM_GAIN, 32'h1ffff);
                write_reg(CFG_SENS_LEAK, 32'h1ffff);
                write_reg(CFG_ADAPT_LEAK, 32'h1ffff);
                write_reg(CFG_THRESHOLD, 32'h7fff_ffff);
                write_reg(CFG_JUMP, 32'h7fff_ffff);
            end
            1: begin
                write_reg(CFG_MODE, 32'd0);
                write_reg(CFG_CUR_LEAK, 32'd0);
                write_reg(CFG_MEM_LEAK, 32'd0);
                write_reg(CFG_MEM_GAIN, 32'd65536);
                write_reg(CFG_SENS_LEAK, 32'd0);
                write_reg(CFG_ADAPT_LEAK, 32'd0);
                write_reg(CFG_THRESHOLD, 32'h8000_0000);
                write_reg(CFG_JUMP, 32'd0);
            end
            default: begin
                write_reg(CFG_MODE, $urandom_range(0, 3));
                write_reg(CFG_CUR_LEAK, $urandom_range(40000, 65536));
                write_reg(CFG_MEM_LEAK, $urandom_range(40000, 65536));
                write_reg(CFG_MEM_GAIN, ($urandom_range(0, 3) == 0) ? $urandom
                                                                     : $urandom_range(0, 65536));
                write_reg(CFG_SENS_LEAK, $urandom_range(0, 65536));
                write_reg(CFG_ADAPT_LEAK, $urandom_range(30000, 65536));
                write_reg(CFG_THRESHOLD, ($urandom_range(0, 3) == 0) ? $urandom
                                                                    : $urandom_range(0, 32'h60000));
                write_reg(CFG_JUMP, ($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(0, 32'h30000));
            end
        endcase
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under reset configuration, then with gain enabled.
        pending_words.push_back(mk(KIND_ARRIVE, 10'd0, PATH_FF, 32'h7fff_ffff, 2'd1, 0, 0, 0, 0, 0));
        pending_words.push_back(mk(KIND_ARRIVE, 10'd0, PATH_FF, 32'h7fff_ffff, 2'd1, 0, 0, 0, 0, 0));
        pending_words.push_back(mk(KIND_ARRIVE, 10'd0, PATH_PRED, 32'h8000_0000, 2'd3, 0, 0, 0, 0, 0));
        pending_words.push_back(mk(KIND_ARRIVE, 10'd0, 2'd2, 32'h8000_0000, 2'd2, 0, 0, 0, 0, 0));
        pending_words.push_back(mk(KIND_ARRIVE, 10'd0, 2'd3, 32'h0001_0000, 2'd0, 0, 0, 0, 0, 0));
        pending_words.push_back(mk(KIND_ARRIVE, 10'd1023, 2'd3, 32'h0003_0000, 2'd1, 0, 0, 0, 0, 0));
        pending_words.push_back(mk(KIND_UPDATE, 10'd0, 0, 0, 0, 17'h1ffff, 17'h1ffff,
                                   32'h7fff_ffff, 32'h8000_0000, 1'b0));
        pending_words.push_back(mk(KIND_UPDATE, 10'd1023, 0, 0, 0, 0, 0,
                                   32'h8000_0000, 32'h7fff_ffff, 1'b1));
        pending_words.push_back(mk(KIND_LEAK, 10'd0, 0, 0, 0, 17'h1ffff, 0, 0, 0, 0));
        pending_words.push_back(mk(KIND_NONE, 10'd0, 0, 32'hffff_ffff, 2'd1, 0, 0, 0, 0, 1'b1));
        pending_words.push_back(mk(KIND_UPDATE, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_idle();
        write_reg(CFG_MEM_GAIN, 32'd65536);
        pending_words.push_back(mk(KIND_ARRIVE, 10'd5, PATH_FF, 32'h0004_0000, 2'd1, 0, 0, 0, 0, 0));
        // Fires, then two refractory updates, then eligible again.
        for (int i = 0; i < 4; i++)
            pending_words.push_back(mk(KIND_UPDATE, 10'd5, 0, 0, 0, 0, 0, 32'h0002_0000, 0, 0));
        pending_words.push_back(mk(KIND_UPDATE, 10'd5, 0, 0, 0, 0, 0, 32'h0008_0000, 0, 1'b1));
        pending_words.push_back(mk(KIND_LEAK, 10'd5, 0, 0, 0, 17'd0, 0, 0, 0, 0));
        pending_words.push_back(mk(KIND_UPDATE, 10'd5, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            configure(ph);
            quiet = (ph == 4);
            for (int i = 0; i < 125; i++) begin
                pending_words.push_back(rand_word());
                if (ph == 3 && i == 60) wait_idle();
            end
            wait_idle();
        end

        repeat (30) @(posedge aclk);
        if (fails == 0) begin
            $display("lif_neuron_core_step_core regression: pass");
        end else begin
            $display("lif_neuron_core_step_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lifn_pkg.sv
rtl/lifn_front.sv
rtl/lifn_fifo.sv
rtl/lifn_back.sv
rtl/lif_neuron_core_step_core.sv
dv/tb_lif_neuron_core_step_core.sv
